@@ rtl/tfn_pkg.sv @@
package tfn_pkg;

  // Field widths of the triangle and normal items.
  localparam int COORD_BITS       = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int OUT_BITS         = 16;

  // Internal datapath widths, derived from the field widths except NRM_W.
  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int NRM_W   = 31;
  localparam int NRM_TOP = NRM_W - 1;
  localparam int WIDE_W  = MAG_W + NRM_TOP;
  localparam int PIDX_W  = $clog2(MAG_W);
  localparam int SQ_W    = 2 * NRM_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int QUO_W   = NORMAL_FRAC_BITS + 1;

  // One triangle.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_a_z;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_b_z;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] vertex_c_z;
    logic                         final_triangle;
  } tri_in_t;

  // One unit face normal.
  typedef struct packed {
    logic signed [OUT_BITS-1:0] normal_x;
    logic signed [OUT_BITS-1:0] normal_y;
    logic signed [OUT_BITS-1:0] normal_z;
    logic                       degenerate;
    logic                       final_normal;
  } nrm_out_t;

  // Side information that travels alongside the square root.
  typedef struct packed {
    logic [2:0][NRM_W-1:0] mag;
    logic [2:0]            neg;
    logic                  degenerate;
    logic                  final_tri;
  } sq_tag_t;

  // Side information that travels alongside the division.
  typedef struct packed {
    logic [2:0] neg;
    logic       degenerate;
    logic       final_tri;
  } div_tag_t;

endpackage

@@ rtl/tfn_sqrt.sv @@
module tfn_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [tfn_pkg::SUM_W-1:0]   rad_i,
  input  tfn_pkg::sq_tag_t            tag_i,
  output logic                        valid_o,
  output logic [tfn_pkg::ROOT_W-1:0]  root_o,
  output tfn_pkg::sq_tag_t            tag_o
);
  import tfn_pkg::*;

  // Stage registers: one root bit is settled per stage.
  logic [SUM_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  sq_tag_t           tag_q  [ROOT_W];
  logic              vld_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [SUM_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    sq_tag_t           tag_in;
    logic              vld_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = tag_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign tag_in  = tag_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        tag_q[k]  <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign tag_o   = tag_q[ROOT_W-1];

endmodule

@@ rtl/tfn_div.sv @@
module tfn_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [2:0][tfn_pkg::NRM_W-1:0]        mag_i,
  input  logic [tfn_pkg::ROOT_W-1:0]            den_i,
  input  tfn_pkg::div_tag_t                     tag_i,
  output logic                                  valid_o,
  output logic [2:0][tfn_pkg::QUO_W-1:0]        quo_o,
  output tfn_pkg::div_tag_t                     tag_o
);
  import tfn_pkg::*;

  // Stage registers: one quotient bit of each component per stage.
  logic [2:0][ROOT_W-1:0] rem_q [QUO_W];
  logic [2:0][QUO_W-1:0]  quo_q [QUO_W];
  logic [ROOT_W-1:0]      den_q [QUO_W];
  div_tag_t               tag_q [QUO_W];
  logic                   vld_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [ROOT_W:0]        x [3];
    logic [2:0][QUO_W-1:0]  quo_in;
    logic [ROOT_W-1:0]      den_in;
    div_tag_t               tag_in;
    logic                   vld_in;
    logic [2:0]             ge;
    logic [2:0][ROOT_W-1:0] rem_d;
    logic [2:0][QUO_W-1:0]  quo_d;

    if (k == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_x
        assign x[i] = (ROOT_W+1)'(mag_i[i]);
      end
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      for (genvar i = 0; i < 3; i++) begin : g_x
        assign x[i] = {rem_q[k-1][i], 1'b0};
      end
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    // Restoring step for the three components in parallel.
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i]    = (x[i] >= {1'b0, den_in});
        rem_d[i] = ge[i] ? ROOT_W'(x[i] - {1'b0, den_in}) : ROOT_W'(x[i]);
        quo_d[i] = {quo_in[i][QUO_W-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign tag_o   = tag_q[QUO_W-1];

endmodule

@@ rtl/triangle_face_normal.sv @@
// Triangle unit face normal, fully pipelined.
// After its triangle's transfer edge, a result passes through
// eight arithmetic stages, 32 square-root stages, 15 divider stages and the output register.
// Throughput: one triangle per cycle while the output is taken; a skid register
// holds one result when the output stalls, and the pipeline then freezes.
// Reset clears all valid bits, the skid register's among them; payload is not reset.
module triangle_face_normal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tfn_pkg::tri_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tfn_pkg::nrm_out_t  out_data_o
);
  import tfn_pkg::*;

  localparam int FRONT_STAGES = 8;

  logic adv;
  logic [FRONT_STAGES-1:0] stg_vld_q;
  logic out_vld_q, skid_vld_q;

  // Front-end payload registers.
  logic signed [EDGE_W-1:0]  e1_d [3];
  logic signed [EDGE_W-1:0]  e2_d [3];
  logic signed [EDGE_W-1:0]  e1_q [3];
  logic signed [EDGE_W-1:0]  e2_q [3];
  logic signed [PROD_W-1:0]  prod_q [6];
  logic signed [CROSS_W-1:0] cross_q [3];
  logic [2:0][MAG_W-1:0]     mag_q;
  logic [2:0][MAG_W-1:0]     mag5_q;
  logic [2:0][NRM_W-1:0]     nrm_q;
  logic [2:0][SQ_W-1:0]      sq_q;
  logic [SUM_W-1:0]          sum_q;
  logic [2:0][NRM_W-1:0]     nrm7_q;
  logic [2:0][NRM_W-1:0]     nrm8_q;
  logic [2:0]                neg4_q, neg5_q, neg6_q, neg7_q, neg8_q;
  logic                      deg5_q, deg6_q, deg7_q, deg8_q;
  logic [FRONT_STAGES-1:0]   fin_q;
  logic [PIDX_W-1:0]         pidx_d, pidx_q;
  logic [MAG_W-1:0]          mag_or;

  // The pipeline moves as long as the skid register is free.
  assign adv        = !skid_vld_q;
  assign in_ready_o = adv;

  // Edge vectors from the first vertex.
  always_comb begin
    e1_d[0] = EDGE_W'(in_data_i.vertex_b_x) - EDGE_W'(in_data_i.vertex_a_x);
    e1_d[1] = EDGE_W'(in_data_i.vertex_b_y) - EDGE_W'(in_data_i.vertex_a_y);
    e1_d[2] = EDGE_W'(in_data_i.vertex_b_z) - EDGE_W'(in_data_i.vertex_a_z);
    e2_d[0] = EDGE_W'(in_data_i.vertex_c_x) - EDGE_W'(in_data_i.vertex_a_x);
    e2_d[1] = EDGE_W'(in_data_i.vertex_c_y) - EDGE_W'(in_data_i.vertex_a_y);
    e2_d[2] = EDGE_W'(in_data_i.vertex_c_z) - EDGE_W'(in_data_i.vertex_a_z);
  end

  // Position of the top set bit over all three magnitudes.
  always_comb begin
    mag_or = mag_q[0] | mag_q[1] | mag_q[2];
    pidx_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag_or[i]) begin
        pidx_d = PIDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= '0;
    end else if (adv) begin
      stg_vld_q <= {stg_vld_q[FRONT_STAGES-2:0], in_valid_i};
    end
  end

  // Front-end arithmetic stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 1: edges.
      e1_q <= e1_d;
      e2_q <= e2_d;
      fin_q <= {fin_q[FRONT_STAGES-2:0], in_data_i.final_triangle};
      // Stage 2: the six cross-product terms.
      prod_q[0] <= e1_q[1] * e2_q[2];
      prod_q[1] <= e1_q[2] * e2_q[1];
      prod_q[2] <= e1_q[2] * e2_q[0];
      prod_q[3] <= e1_q[0] * e2_q[2];
      prod_q[4] <= e1_q[0] * e2_q[1];
      prod_q[5] <= e1_q[1] * e2_q[0];
      // Stage 3: cross product.
      for (int i = 0; i < 3; i++) begin
        cross_q[i] <= CROSS_W'(prod_q[2*i]) - CROSS_W'(prod_q[2*i+1]);
      end
      // Stage 4: sign and magnitude.
      for (int i = 0; i < 3; i++) begin
        neg4_q[i] <= cross_q[i][CROSS_W-1];
        mag_q[i]  <= cross_q[i][CROSS_W-1] ? MAG_W'(-cross_q[i]) : MAG_W'(cross_q[i]);
      end
      // Stage 5: normalising shift amount and the zero test.
      pidx_q <= pidx_d;
      mag5_q <= mag_q;
      neg5_q <= neg4_q;
      deg5_q <= (mag_or == '0);
      // Stage 6: common shift that puts the largest magnitude at bit 30.
      for (int i = 0; i < 3; i++) begin
        nrm_q[i] <= NRM_W'({mag5_q[i], {NRM_TOP{1'b0}}} >> pidx_q);
      end
      neg6_q <= neg5_q;
      deg6_q <= deg5_q;
      // Stage 7: squares.
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= nrm_q[i] * nrm_q[i];
      end
      nrm7_q <= nrm_q;
      neg7_q <= neg6_q;
      deg7_q <= deg6_q;
      // Stage 8: sum of squares.
      sum_q  <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      nrm8_q <= nrm7_q;
      neg8_q <= neg7_q;
      deg8_q <= deg7_q;
    end
  end

  // Square root of the sum of squares.
  sq_tag_t          sq_tag_in, sq_tag_out;
  logic             sq_vld;
  logic [ROOT_W-1:0] root;

  always_comb begin
    sq_tag_in.mag        = nrm8_q;
    sq_tag_in.neg        = neg8_q;
    sq_tag_in.degenerate = deg8_q;
    sq_tag_in.final_tri  = fin_q[FRONT_STAGES-1];
  end

  tfn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (stg_vld_q[FRONT_STAGES-1]),
    .rad_i   (sum_q),
    .tag_i   (sq_tag_in),
    .valid_o (sq_vld),
    .root_o  (root),
    .tag_o   (sq_tag_out)
  );

  // Division of each magnitude by the length.
  div_tag_t              dv_tag_in, dv_tag_out;
  logic                  dv_vld;
  logic [2:0][QUO_W-1:0] quo;

  always_comb begin
    dv_tag_in.neg        = sq_tag_out.neg;
    dv_tag_in.degenerate = sq_tag_out.degenerate;
    dv_tag_in.final_tri  = sq_tag_out.final_tri;
  end

  tfn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_vld),
    .mag_i   (sq_tag_out.mag),
    .den_i   (root),
    .tag_i   (dv_tag_in),
    .valid_o (dv_vld),
    .quo_o   (quo),
    .tag_o   (dv_tag_out)
  );

  // Signs back on, degenerate triangles forced to zero.
  logic [2:0][OUT_BITS-1:0] comp;
  nrm_out_t                 out_d, out_q, skid_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_tag_out.degenerate) begin
        comp[i] = '0;
      end else if (dv_tag_out.neg[i]) begin
        comp[i] = -OUT_BITS'(quo[i]);
      end else begin
        comp[i] = OUT_BITS'(quo[i]);
      end
    end
    out_d.normal_x     = comp[0];
    out_d.normal_y     = comp[1];
    out_d.normal_z     = comp[2];
    out_d.degenerate   = dv_tag_out.degenerate;
    out_d.final_normal = dv_tag_out.final_tri;
  end

  // Output register and skid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_q <= dv_vld;
      end
      if (adv && out_vld_q && !out_ready_i) begin
        skid_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        skid_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
    if (adv && out_vld_q && !out_ready_i) begin
      skid_q <= out_q;
    end
  end

  assign out_valid_o = skid_vld_q | out_vld_q;
  assign out_data_o  = skid_vld_q ? skid_q : out_q;

  // A degenerate result carries a zero normal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |->
      (out_data_o.normal_x == '0 && out_data_o.normal_y == '0 &&
       out_data_o.normal_z == '0))
    else $error("degenerate result with non-zero normal");

  // The skid register only fills when the output register's result stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !out_ready_i))
    else $error("skid register filled without an output stall");

  // A held skid result is neither lost nor altered before its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !out_ready_i) |=> (skid_vld_q && $stable(skid_q)))
    else $error("skid result changed before transfer");

endmodule

@@ verif/tfn_checker.sv @@
`timescale 1ns / 100ps

module tfn_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  tfn_pkg::tri_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  tfn_pkg::nrm_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import tfn_pkg::*;

  nrm_out_t expected_normals[$];

  assign pending_o = expected_normals.size();

  // Integer square root, rounded down.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] op);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > op) bitv >>= 2;
    while (bitv != 0) begin
      if (op >= root + bitv) begin
        op   = op - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Unit face normal of one triangle, in Q2.14.
  function automatic nrm_out_t face_normal(input tri_in_t t);
    nrm_out_t          res;
    longint            e1[3];
    longint            e2[3];
    longint            cr[3];
    logic [63:0]       mag[3];
    logic [63:0]       peak;
    logic [63:0]       sumsq;
    logic [63:0]       root;
    logic [63:0]       quo;
    e1[0] = longint'(t.vertex_b_x) - longint'(t.vertex_a_x);
    e1[1] = longint'(t.vertex_b_y) - longint'(t.vertex_a_y);
    e1[2] = longint'(t.vertex_b_z) - longint'(t.vertex_a_z);
    e2[0] = longint'(t.vertex_c_x) - longint'(t.vertex_a_x);
    e2[1] = longint'(t.vertex_c_y) - longint'(t.vertex_a_y);
    e2[2] = longint'(t.vertex_c_z) - longint'(t.vertex_a_z);
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    res = '0;
    res.final_normal = t.final_triangle;
    peak = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (cr[i] < 0) ? -cr[i] : cr[i];
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    // Normalise so that the largest magnitude sits in [2^30, 2^31).
    while (peak >= 64'd1 << 31) begin
      peak >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (peak < 64'd1 << 30) begin
      peak <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    sumsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    root  = floor_sqrt(sumsq);
    quo = (mag[0] << NORMAL_FRAC_BITS) / root;
    res.normal_x = (cr[0] < 0) ? -quo[15:0] : quo[15:0];
    quo = (mag[1] << NORMAL_FRAC_BITS) / root;
    res.normal_y = (cr[1] < 0) ? -quo[15:0] : quo[15:0];
    quo = (mag[2] << NORMAL_FRAC_BITS) / root;
    res.normal_z = (cr[2] < 0) ? -quo[15:0] : quo[15:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  // Predict on each input transfer and compare on each output transfer.
  always @(posedge clk_i) begin
    nrm_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) expected_normals.push_back(face_normal(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_normals.size() == 0) begin
          report_mismatch("normal with no triangle outstanding");
        end else begin
          want = expected_normals.pop_front();
          if (out_data_i.normal_x !== want.normal_x)
            report_mismatch($sformatf("normal_x %0d, wanted %0d",
                                      out_data_i.normal_x, want.normal_x));
          if (out_data_i.normal_y !== want.normal_y)
            report_mismatch($sformatf("normal_y %0d, wanted %0d",
                                      out_data_i.normal_y, want.normal_y));
          if (out_data_i.normal_z !== want.normal_z)
            report_mismatch($sformatf("normal_z %0d, wanted %0d",
                                      out_data_i.normal_z, want.normal_z));
          if (out_data_i.degenerate !== want.degenerate)
            report_mismatch($sformatf("degenerate %b, wanted %b",
                                      out_data_i.degenerate, want.degenerate));
          if (out_data_i.final_normal !== want.final_normal)
            report_mismatch($sformatf("final_normal %b, wanted %b",
                                      out_data_i.final_normal, want.final_normal));
        end
      end
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import tfn_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tri_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  nrm_out_t out_data;
  int       fail_count;
  int       pending;
  int       cycle_count;
  int       send_idle_pct;
  int       recv_stall_pct;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TRI_W       = $bits(tri_in_t);

  triangle_face_normal u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  tfn_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[triangle_face_normal] ERROR");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Random coordinate, biased towards extremes and small values.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tri_in_t random_triangle();
    tri_in_t t;
    t = TRI_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(9))
      // Fully random triangle.
      0, 1, 2, 3: ;
      // Biased coordinates.
      4, 5, 6: begin
        t.vertex_a_x = pick_coord(); t.vertex_a_y = pick_coord();
        t.vertex_a_z = pick_coord(); t.vertex_b_x = pick_coord();
        t.vertex_b_y = pick_coord(); t.vertex_b_z = pick_coord();
        t.vertex_c_x = pick_coord(); t.vertex_c_y = pick_coord();
        t.vertex_c_z = pick_coord();
      end
      // Small triangle near a random point.
      7: begin
        t.vertex_b_x = t.vertex_a_x + 16'($urandom_range(3));
        t.vertex_b_y = t.vertex_a_y + 16'($urandom_range(3));
        t.vertex_b_z = t.vertex_a_z + 16'($urandom_range(3));
        t.vertex_c_x = t.vertex_a_x + 16'($urandom_range(3));
        t.vertex_c_y = t.vertex_a_y + 16'($urandom_range(3));
        t.vertex_c_z = t.vertex_a_z + 16'($urandom_range(3));
      end
      // Degenerate: two coincident vertices.
      8: begin
        t.vertex_c_x = t.vertex_b_x;
        t.vertex_c_y = t.vertex_b_y;
        t.vertex_c_z = t.vertex_b_z;
      end
      // Collinear vertices.
      default: begin
        t.vertex_b_x = t.vertex_a_x + 16'd5;
        t.vertex_b_y = t.vertex_a_y - 16'd3;
        t.vertex_b_z = t.vertex_a_z + 16'd1;
        t.vertex_c_x = t.vertex_a_x + 16'd10;
        t.vertex_c_y = t.vertex_a_y - 16'd6;
        t.vertex_c_z = t.vertex_a_z + 16'd2;
      end
    endcase
    return t;
  endfunction

  // Offer one triangle, idling first at random; hold it until the transfer.
  task automatic send_triangle(input tri_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic tri_in_t make_tri(input logic [15:0] ax, ay, az, bx, by, bz,
                                       cx, cy, cz, input logic last);
    return '{ax, ay, az, bx, by, bz, cx, cy, cz, last};
  endfunction

  initial begin
    tri_in_t directed[$];
    int      idle_mode;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: axis-aligned normals, extremes, degenerate and tiny cases.
    directed.push_back(make_tri(0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0, 1'b0));
    directed.push_back(make_tri(0, 0, 0, 0, 16'h0100, 0, 16'h0100, 0, 0, 1'b1));
    directed.push_back(make_tri(0, 0, 0, 0, 0, 16'h0100, 16'h0100, 0, 0, 1'b0));
    directed.push_back(make_tri(0, 0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 1'b0));
    directed.push_back(make_tri(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                                16'h8000, 16'h8000, 16'h7fff, 16'h8000, 1'b0));
    directed.push_back(make_tri(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                                16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1));
    directed.push_back(make_tri(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                                16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0));
    directed.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    directed.push_back(make_tri(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1));
    directed.push_back(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9, 1'b0));
    directed.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0));
    directed.push_back(make_tri(0, 0, 0, 1, 1, 0, 1, 2, 0, 1'b0));
    // One large and two small components, one of them zero: the small ones come out as zero.
    directed.push_back(make_tri(16'h8000, 0, 0, 16'h7fff, 0, 1, 16'h8000, 16'h7fff, 0,
                                1'b0));
    directed.push_back(make_tri(0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
                                16'h7fff, 16'h8000, 1'b1));
    directed.push_back(make_tri(0, 0, 0, 16'h0100, 16'h0100, 0, 16'hff00, 16'h0100, 0,
                                1'b0));
    foreach (directed[i]) send_triangle(directed[i]);

    // Random phases with different idling patterns.
    for (int phase = 0; phase < 8; phase++) begin
      idle_mode = phase % 4;
      send_idle_pct  = (idle_mode == 1) ? 67 : (idle_mode == 3) ? 25 : 0;
      recv_stall_pct = (idle_mode == 2) ? 67 : (idle_mode == 3) ? 25 : 0;
      repeat (142) send_triangle(random_triangle());
    end
    in_valid <= 1'b0;
    recv_stall_pct = 20;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[triangle_face_normal] OK");
    end else begin
      $display("[triangle_face_normal] ERROR");
    end
    $finish;
  end

endmodule

@@ triangle_face_normal.f @@
rtl/tfn_pkg.sv
rtl/tfn_sqrt.sv
rtl/tfn_div.sv
rtl/triangle_face_normal.sv
verif/tfn_checker.sv
verif/testbench.sv
